>>> hdl/tsox_pkg.sv
// Package for the TCP SACK option extractor: payload types, walk states, field constants.
package tsox_pkg;

	// Input transaction: one frame byte plus the end-of-frame mark
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_item_t;

	// Output transaction: one SACK header or block record
	typedef struct packed {
		logic        record_kind;
		logic [31:0] sack_option_number;
		logic [2:0]  block_count;
		logic [1:0]  block_index;
		logic [31:0] block_left_edge;
		logic [31:0] block_right_edge;
	} out_item_t;

	// Option walk states, one-hot
	typedef enum logic [3:0] {
		WALK_KIND = 4'b0001,
		WALK_LEN  = 4'b0010,
		WALK_BODY = 4'b0100,
		WALK_DONE = 4'b1000
	} walk_mode_t;

	// Record kinds
	localparam logic REC_HEADER = 1'b0;
	localparam logic REC_BLOCK  = 1'b1;

	// Frame byte offsets of fixed header fields
	localparam logic [7:0] POS_ETH_HI = 8'd12;
	localparam logic [7:0] POS_ETH_LO = 8'd13;
	localparam logic [7:0] POS_IHL    = 8'd14;
	localparam logic [7:0] POS_PROTO  = 8'd23;
	localparam logic [7:0] POS_MAX    = 8'd255;

	// Header values that select a frame
	localparam logic [7:0] ETH_TYPE_HI = 8'h08;
	localparam logic [7:0] ETH_TYPE_LO = 8'h00;
	localparam logic [7:0] PROTO_TCP   = 8'd6;

	// TCP header layout
	localparam logic [7:0] TCP_DOFF_OFS  = 8'd12;
	localparam logic [7:0] TCP_HDR_BYTES = 8'd20;
	localparam logic [3:0] TCP_DOFF_MIN  = 4'd5;

	// Option kinds and sizes
	localparam logic [7:0] OPT_END     = 8'd0;
	localparam logic [7:0] OPT_NOP     = 8'd1;
	localparam logic [7:0] OPT_SACK    = 8'd5;
	localparam logic [7:0] OPT_LEN_MIN = 8'd2;
	localparam logic [2:0] EDGE_LAST   = 3'd7;

endpackage

>>> hdl/tsox_walker.sv
// Frame byte parser and TCP option walker; produces at most one record per byte.
module tsox_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  tsox_pkg::in_item_t  in_data,
	output logic                res_valid,
	output tsox_pkg::out_item_t res_data
);
	import tsox_pkg::*;

	logic [7:0]  pos_q, n_pos;
	logic        acc_q, n_acc;
	logic [7:0]  eth_hi_q, n_eth_hi;
	logic [3:0]  ihl_q, n_ihl;
	logic [5:0]  total_q, n_total;
	walk_mode_t  mode_q, n_mode;
	logic [7:0]  left_q, n_left;
	logic        sack_q, n_sack;
	logic [63:0] shift_q, n_shift;
	logic [2:0]  cnt_q, n_cnt;
	logic [2:0]  blk_q, n_blk;
	logic [31:0] sack_cnt_q, n_sack_cnt;

	logic [7:0] b;
	logic [7:0] tcp_start;
	logic [7:0] opt_start;
	logic [7:0] idx;
	logic [7:0] len_m2;
	logic [7:0] left_dec;
	logic [8:0] opt_end;
	logic [3:0] doff;

	// Header field positions follow from the IHL
	assign b         = in_data.frame_byte;
	assign tcp_start = 8'd14 + {2'b00, ihl_q, 2'b00};
	assign opt_start = tcp_start + TCP_HDR_BYTES;
	assign idx       = pos_q - opt_start;
	assign len_m2    = b - OPT_LEN_MIN;
	assign left_dec  = left_q - 8'd1;
	assign opt_end   = {1'b0, idx} - 9'd1 + {1'b0, b};
	assign doff      = b[7:4];

	// Next state and record for the accepted byte
	always_comb begin
		n_pos      = pos_q;
		n_acc      = acc_q;
		n_eth_hi   = eth_hi_q;
		n_ihl      = ihl_q;
		n_total    = total_q;
		n_mode     = mode_q;
		n_left     = left_q;
		n_sack     = sack_q;
		n_shift    = shift_q;
		n_cnt      = cnt_q;
		n_blk      = blk_q;
		n_sack_cnt = sack_cnt_q;
		res_valid  = 1'b0;
		res_data   = '0;
		if (in_fire) begin
			if (acc_q) begin
				if (pos_q == POS_ETH_HI) begin
					n_eth_hi = b;
				end else if (pos_q == POS_ETH_LO) begin
					if (eth_hi_q != ETH_TYPE_HI || b != ETH_TYPE_LO)
						n_acc = 1'b0;
				end else if (pos_q == POS_IHL) begin
					n_ihl = b[3:0];
				end else if (pos_q == POS_PROTO) begin
					if (b != PROTO_TCP)
						n_acc = 1'b0;
				end else if (pos_q == tcp_start + TCP_DOFF_OFS) begin
					n_total = (doff > TCP_DOFF_MIN) ? ({doff, 2'b00} - 6'd20) : 6'd0;
				end else if (pos_q >= opt_start && mode_q != WALK_DONE) begin
					if (idx >= {2'b00, total_q}) begin
						n_mode = WALK_DONE;
					end else begin
						case (mode_q)
							WALK_KIND: begin
								if (b == OPT_END) begin
									n_mode = WALK_DONE;
								end else if (b != OPT_NOP) begin
									n_sack = (b == OPT_SACK);
									n_mode = WALK_LEN;
								end
							end
							WALK_LEN: begin
								if (b < OPT_LEN_MIN || opt_end > {3'b000, total_q}) begin
									n_mode = WALK_DONE;
								end else begin
									n_left  = len_m2;
									n_shift = '0;
									n_cnt   = '0;
									n_blk   = '0;
									n_mode  = (len_m2 == 8'd0) ? WALK_KIND : WALK_BODY;
									if (sack_q) begin
										res_valid                   = 1'b1;
										res_data.record_kind        = REC_HEADER;
										res_data.sack_option_number = sack_cnt_q;
										res_data.block_count        = len_m2[5:3];
										n_sack_cnt                  = sack_cnt_q + 32'd1;
									end
								end
							end
							WALK_BODY: begin
								n_left = left_dec;
								if (left_dec == 8'd0)
									n_mode = WALK_KIND;
								if (sack_q) begin
									n_shift = {shift_q[55:0], b};
									if (cnt_q != EDGE_LAST) begin
										n_cnt = cnt_q + 3'd1;
									end else begin
										n_cnt                       = '0;
										res_valid                   = 1'b1;
										res_data.record_kind        = REC_BLOCK;
										res_data.sack_option_number = sack_cnt_q - 32'd1;
										res_data.block_count        = blk_q + 3'd1 + left_dec[5:3];
										res_data.block_index        = blk_q[1:0];
										res_data.block_left_edge    = n_shift[63:32];
										res_data.block_right_edge   = n_shift[31:0];
										n_blk                       = blk_q + 3'd1;
									end
								end
							end
							default: begin
								n_mode = WALK_DONE;
							end
						endcase
					end
				end
			end
			if (pos_q != POS_MAX)
				n_pos = pos_q + 8'd1;
			// Last byte: per-frame state returns to reset, option count is kept
			if (in_data.frame_end) begin
				n_pos    = '0;
				n_acc    = 1'b1;
				n_eth_hi = '0;
				n_ihl    = '0;
				n_total  = '0;
				n_mode   = WALK_KIND;
				n_left   = '0;
				n_sack   = 1'b0;
				n_shift  = '0;
				n_cnt    = '0;
				n_blk    = '0;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			acc_q      <= 1'b1;
			eth_hi_q   <= '0;
			ihl_q      <= '0;
			total_q    <= '0;
			mode_q     <= WALK_KIND;
			left_q     <= '0;
			sack_q     <= 1'b0;
			shift_q    <= '0;
			cnt_q      <= '0;
			blk_q      <= '0;
			sack_cnt_q <= 32'd1;
		end else begin
			pos_q      <= n_pos;
			acc_q      <= n_acc;
			eth_hi_q   <= n_eth_hi;
			ihl_q      <= n_ihl;
			total_q    <= n_total;
			mode_q     <= n_mode;
			left_q     <= n_left;
			sack_q     <= n_sack;
			shift_q    <= n_shift;
			cnt_q      <= n_cnt;
			blk_q      <= n_blk;
			sack_cnt_q <= n_sack_cnt;
		end
	end

	// A record only comes from an accepted byte of a kept frame mid-walk
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_fire && acc_q && (mode_q == WALK_LEN || mode_q == WALK_BODY))
		else $error("record outside an option walk");

	// A block record closes a full eight-byte block
	a_blk_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.record_kind == REC_BLOCK |-> cnt_q == EDGE_LAST && sack_q)
		else $error("block record before eight edge bytes");

	// End of frame restarts the parser
	a_frame_clr: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.frame_end |=> pos_q == 8'd0 && acc_q && mode_q == WALK_KIND)
		else $error("per-frame state not cleared");

	// Header records advance the option number by one
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.record_kind == REC_HEADER |=>
			sack_cnt_q == $past(sack_cnt_q) + 32'd1)
		else $error("option number did not advance");

endmodule

>>> hdl/tsox_out_reg.sv
// Output register stage: holds one record until the downstream side takes it.
module tsox_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tsox_pkg::out_item_t load_data,
	output logic                slot_free,
	output logic                out_valid,
	input  logic                out_ready,
	output tsox_pkg::out_item_t out_data
);
	import tsox_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// Slot is free when empty or being drained this cycle
	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Record payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	// A loaded record is presented on the next cycle
	a_load_show: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && data_q == $past(load_data))
		else $error("loaded record not presented");

	// Never load over a record that is not being taken
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("record overwritten");

endmodule

>>> hdl/tcp_sack_option_extractor.sv
// Top level of the TCP SACK option extractor: byte parser feeding an output register.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------
//  input     | in_valid / in_ready   | in_data  (frame_byte, frame_end)
//  output    | out_valid / out_ready | out_data (SACK header/block record)
//
// One frame byte is accepted per cycle while in_ready is high; its record, if
// any, appears on the output in the cycle after the byte is accepted.
// in_ready is high while the output register is empty or being drained, so
// a stalled output holds one record and stops input only while it waits.
// Reset clears all parser state and sets the SACK option number to 1.
// The option number carries across frames; frame_end clears everything else.
module tcp_sack_option_extractor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsox_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsox_pkg::out_item_t out_data
);
	import tsox_pkg::*;

	logic      in_fire;
	logic      res_valid;
	out_item_t res_data;

	assign in_fire = in_valid && in_ready;

	// Parser and option walk
	tsox_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// Result register
	tsox_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_data (res_data),
		.slot_free (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
